/* rtl/core/md5_pkg.sv */
`default_nettype none
package md5_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB  = 2'd0,
    OP_DIGEST  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
  } cmd_t;

  function automatic logic [31:0] k_add(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] k_rot(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word index used by a round
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    logic [7:0] t;
    t = '0;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: begin t = 8'(5 * i + 1); g = t[3:0]; end
      2'd2: begin t = 8'(3 * i + 5); g = t[3:0]; end
      default: begin t = 8'(7 * i); g = t[3:0]; end
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/md5_hash_engine.sv */
// MD5 engine, one command per input transfer.
// Input: s_axis_tuser[1:0] = op (0 absorb, 1 digest, 2 restart; 3 is dropped),
//   s_axis_tdata[7:0] = data_byte.
// Output: m_axis_tdata[31:0] = digest_word, [33:32] = word_index,
//   m_axis_tlast = last_word (fourth word of a digest).
// A two-entry command queue decouples the front from the back end.
// An absorb is taken from the idle state and writes its byte to the buffer;
// the 64th byte of a block adds a buffer load, 64 rounds (one round a cycle)
// and a fold. Digest runs one or two padded compressions, then issues four
// word transfers, one a cycle while the receiver is ready; the running hash
// is unchanged.
// Restart reloads the initial chaining words and clears the count.
// Reset: chaining words take their initial values, count clears, queue
// empties; the byte buffer is not cleared.
// When the receiver stalls, the current word holds and the queue fills,
// then s_axis_tready drops.
`default_nettype none
module md5_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic [1:0]  s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // digest_word, word_index
  output logic             m_axis_tlast   // last_word
);
  import md5_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  md5_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .s_tuser_i(s_axis_tuser),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  md5_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_o(m_axis_tdata), .m_tlast_o(m_axis_tlast)
  );
endmodule
`default_nettype wire

/* rtl/core/md5_ram.sv */
`default_nettype none
module md5_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/md5_front.sv */
`default_nettype none
module md5_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  output logic                  s_tready_o,
  input  wire logic [7:0]       s_tdata_i,
  input  wire logic [1:0]       s_tuser_i,
  output logic                  q_valid_o,
  input  wire logic             q_pop_i,
  output md5_pkg::cmd_t         q_cmd_o
);
  import md5_pkg::*;

  cmd_t             buf_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             push;
  cmd_t             in_cmd;

  assign in_cmd     = cmd_t'({s_tuser_i, s_tdata_i});
  assign s_tready_o = (cnt_q != (QPtrW+1)'(QDepth));
  // drop unused op codes here so the back end never sees them
  assign push       = s_tvalid_i && s_tready_o && (in_cmd.op != OP_NONE);
  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (QPtrW+1)'(QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !push) |=> cnt_q == '0)
    else $error("queue count moved without a push");
endmodule
`default_nettype wire

/* rtl/core/md5_back.sv */
`default_nettype none
module md5_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_pop_o,
  input  wire md5_pkg::cmd_t q_cmd_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [39:0]      m_tdata_o,
  output logic             m_tlast_o
);
  import md5_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e      st_q, st_d;
  logic [31:0] h_q [4];
  logic [31:0] t_q [4];  // working copy for digest
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] cnt_q;
  logic [5:0]  rnd_q, pidx_q, rd_idx;
  logic [5:0]  fill;
  logic        dig_q, second_q, pass2_q;
  logic [1:0]  ow_q;
  logic [31:0] w_q [16];
  logic [7:0]  ram_rd;
  logic        ram_we;
  logic [5:0]  ram_wa;
  logic        ld_v_q;

  assign fill = cnt_q[8:3];

  // buffer written on absorb; digest builds its padded block in w_q
  assign ram_we = (st_q == S_IDLE) && q_valid_i && (q_cmd_i.op == OP_ABSORB);
  assign ram_wa = fill;

  md5_ram #(.Width(8), .Depth(64)) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(q_cmd_i.data_byte),
    .raddr_i(rd_idx),
    .rdata_o(ram_rd)
  );

  assign rd_idx  = pidx_q;
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i;

  // byte that goes into w_q at position p (in the cycle after its read)
  logic [5:0] wb_pos_q;
  logic       wb_v_q;
  logic [7:0] wb_byte;
  logic [63:0] cnt_dig_q;
  always_comb begin
    if (!dig_q) begin
      wb_byte = ram_rd;
    end else if (pass2_q) begin
      wb_byte = (wb_pos_q >= LenPos) ? cnt_dig_q[8*(wb_pos_q[2:0]) +: 8] : 8'h00;
    end else if (wb_pos_q < fill) begin
      wb_byte = ram_rd;
    end else if (wb_pos_q == fill) begin
      wb_byte = PadByte;
    end else if (wb_pos_q >= LenPos && fill < LenPos) begin
      wb_byte = cnt_dig_q[8*(wb_pos_q[2:0]) +: 8];
    end else begin
      wb_byte = 8'h00;
    end
  end

  logic [31:0] f, sum, rot, kk;
  logic [4:0]  sh;
  always_comb begin
    case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    kk  = k_add(rnd_q);
    sh  = k_rot(rnd_q);
    sum = a_q + f + w_q[msg_idx(rnd_q)] + kk;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (q_valid_i) begin
        unique case (q_cmd_i.op)
          OP_ABSORB:  st_d = (fill == 6'd63) ? S_LOAD : S_IDLE;
          OP_DIGEST:  st_d = S_LOAD;
          default:    st_d = S_IDLE;
        endcase
      end
      S_LOAD:  if (pidx_q == 6'd63 && ld_v_q && wb_pos_q == 6'd63) st_d = S_ROUND;
      S_ROUND: if (rnd_q == 6'd63) st_d = S_FOLD;
      S_FOLD:  st_d = (dig_q && second_q) ? S_LOAD : (dig_q ? S_OUT : S_IDLE);
      S_OUT:   if (m_tready_i && ow_q == 2'd3) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  logic [31:0] src [4];
  always_comb begin
    for (int k = 0; k < 4; k++) src[k] = dig_q ? t_q[k] : h_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (wb_v_q) begin
      w_q[wb_pos_q[5:2]][8*wb_pos_q[1:0] +: 8] <= wb_byte;
    end
    if (st_q == S_ROUND) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end else begin
      a_q <= src[0]; b_q <= src[1]; c_q <= src[2]; d_q <= src[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
      for (int k = 0; k < 4; k++) t_q[k] <= '0;
      cnt_q <= '0; cnt_dig_q <= '0;
      rnd_q <= '0; pidx_q <= '0; wb_pos_q <= '0; wb_v_q <= 1'b0;
      ld_v_q <= 1'b0;
      dig_q <= 1'b0; second_q <= 1'b0; pass2_q <= 1'b0; ow_q <= '0;
    end else begin
      st_q   <= st_d;
      // a read lands in w_q the cycle after; the last load cycle reads nothing new
      wb_v_q <= (st_q == S_LOAD) && (st_d != S_ROUND);
      unique case (st_q)
        S_IDLE: if (q_valid_i) begin
          pidx_q <= '0; ld_v_q <= 1'b0; pass2_q <= 1'b0;
          unique case (q_cmd_i.op)
            OP_ABSORB: begin
              cnt_q <= cnt_q + 64'd8;
              dig_q <= 1'b0; second_q <= 1'b0;
            end
            OP_DIGEST: begin
              dig_q <= 1'b1;
              second_q <= (fill >= LenPos);
              cnt_dig_q <= cnt_q;
              for (int k = 0; k < 4; k++) t_q[k] <= h_q[k];
            end
            OP_RESTART: begin
              h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
              cnt_q <= '0;
            end
            default: ;
          endcase
        end
        S_LOAD: begin
          // read one byte a cycle; the write lands the cycle after
          wb_pos_q <= pidx_q;
          ld_v_q   <= 1'b1;
          if (pidx_q != 6'd63) pidx_q <= pidx_q + 1'b1;
          if (st_d == S_ROUND) rnd_q <= '0;
        end
        S_ROUND: rnd_q <= rnd_q + 1'b1;
        S_FOLD: begin
          if (dig_q) begin
            t_q[0] <= t_q[0] + a_q; t_q[1] <= t_q[1] + b_q;
            t_q[2] <= t_q[2] + c_q; t_q[3] <= t_q[3] + d_q;
            if (second_q) begin
              second_q <= 1'b0; pass2_q <= 1'b1; pidx_q <= '0; ld_v_q <= 1'b0;
            end
            ow_q <= '0;
          end else begin
            h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
            h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
          end
        end
        S_OUT: if (m_tready_i) ow_q <= ow_q + 1'b1;
        default: ;
      endcase
    end
  end

  assign m_tvalid_o = (st_q == S_OUT);
  assign m_tdata_o  = {6'b0, ow_q, t_q[ow_q]};
  assign m_tlast_o  = (ow_q == 2'd3);

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> st_q == S_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_ROUND && rnd_q == 6'd63) |=> st_q == S_FOLD)
    else $error("round count broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_tvalid_o |-> dig_q)
    else $error("output without digest");
endmodule
`default_nettype wire

/* verif/tb_md5_hash_engine.sv */
module tb_md5_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import md5_pkg::*;

  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_xfer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte
  logic [1:0]  s_axis_tuser = '0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // digest_word, word_index
  logic        m_axis_tlast;        // last_word

  md5_hash_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the hash state.
  logic [31:0]  chain_q [4];
  logic [7:0]   block_q [64];
  logic [63:0]  bit_len_q;
  digest_xfer_t digest_words_q [$];

  int unsigned errors = 0;
  int unsigned ops_sent = 0;
  int unsigned words_seen = 0;
  int unsigned digests_sent = 0;
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Fold one 64-byte block into the chaining words.
  task automatic md5_fold(inout logic [31:0] h [4], input logic [7:0] blk [64]);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    int unsigned rnd;
    int unsigned rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    logic [31:0] kt [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    end
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = a + f + w[g] + kt[i];
      t = b + rotl(t, rot[rnd * 4 + i % 4]);
      a = d; d = c; c = b; b = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
  endtask

  task automatic restart_hash();
    chain_q[0] = InitA; chain_q[1] = InitB; chain_q[2] = InitC; chain_q[3] = InitD;
    bit_len_q = '0;
  endtask

  // Apply one op to the shadow state; queue the four words a digest produces.
  task automatic predict_op(input op_e op, input logic [7:0] data);
    logic [31:0] h [4];
    logic [7:0]  blk [64];
    int unsigned fill;
    fill = int'(bit_len_q[8:3]);
    case (op)
      OP_ABSORB: begin
        block_q[fill] = data;
        bit_len_q += 64'd8;
        if (fill == 63) md5_fold(chain_q, block_q);
      end
      OP_RESTART: restart_hash();
      OP_DIGEST: begin
        h = chain_q;
        blk = block_q;
        blk[fill] = PadByte;
        for (int i = fill + 1; i < 64; i++) blk[i] = '0;
        // no room for the length: an extra all-pad block
        if (fill >= LenPos) begin
          md5_fold(h, blk);
          for (int i = 0; i < 64; i++) blk[i] = '0;
        end
        for (int i = 0; i < 8; i++) blk[LenPos + i] = bit_len_q[8*i +: 8];
        md5_fold(h, blk);
        for (int i = 0; i < 4; i++) begin
          digest_words_q.push_back('{word: h[i], idx: 2'(i), last: (i == 3)});
        end
        digests_sent++;
      end
      default: ;  // unused code: dropped
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Send one op; the prediction is made at the transfer.
  task automatic send_op(input op_e op, input logic [7:0] data);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_op(op, data);
    ops_sent++;
  endtask

  // Receiver: random stall after each word.
  initial begin
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        digest_xfer_t want;
        words_seen++;
        if (digest_words_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, '0);
        end else begin
          want = digest_words_q.pop_front();
          if (m_axis_tdata[31:0] !== want.word)
            report_mismatch("digest_word", m_axis_tdata, {8'd0, want.word});
          if (m_axis_tdata[33:32] !== want.idx)
            report_mismatch("word_index", {38'd0, m_axis_tdata[33:32]}, {38'd0, want.idx});
          if (m_axis_tlast !== want.last)
            report_mismatch("last_word", {39'd0, m_axis_tlast}, {39'd0, want.last});
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end else if (rst_ni) begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      timed_out = 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_bytes(input int unsigned n);
    for (int i = 0; i < n; i++) send_op(OP_ABSORB, 8'($urandom));
  endtask

  // Known vector "abc", unused code, both byte extremes, restart.
  task automatic test_directed();
    send_op(OP_DIGEST, 8'h00);            // empty message
    send_op(OP_ABSORB, 8'h61);
    send_op(OP_ABSORB, 8'h62);
    send_op(OP_ABSORB, 8'h63);
    send_op(OP_DIGEST, 8'hff);
    send_op(OP_NONE, 8'hff);              // must be dropped
    send_op(OP_ABSORB, 8'hff);
    send_op(OP_ABSORB, 8'h00);
    send_op(OP_DIGEST, 8'h00);
    send_op(OP_DIGEST, 8'h00);            // digest leaves the hash unchanged
    send_op(OP_RESTART, 8'h5a);
    send_op(OP_ABSORB, 8'ha5);
    send_op(OP_DIGEST, 8'h00);
    send_op(OP_RESTART, 8'h00);
  endtask

  // Fill positions around the pad boundary and a message past one block.
  task automatic test_pad_boundaries();
    int unsigned lens [4] = '{55, 56, 63, 120};
    foreach (lens[i]) begin
      send_op(OP_RESTART, 8'h00);
      send_bytes(lens[i]);
      send_op(OP_DIGEST, 8'h00);
    end
  endtask

  // Random messages of short lengths, with some noise ops mixed in.
  task automatic test_random_messages();
    int unsigned n;
    while (ops_sent < 360) begin
      send_op(OP_RESTART, 8'($urandom));
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: send_op(OP_DIGEST, 8'($urandom));
          1: send_op(OP_NONE, 8'($urandom));
          default: send_op(OP_ABSORB, 8'($urandom));
        endcase
      end
      send_op(OP_DIGEST, 8'($urandom));
    end
  endtask

  initial begin
    restart_hash();
    for (int i = 0; i < 64; i++) block_q[i] = '0;
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pad_boundaries();
    test_random_messages();
    s_axis_tvalid <= 1'b0;
    wait (digest_words_q.size() == 0 || timed_out);
    repeat (300) @(posedge clk_i);
    $display("covered %0d ops (pad edges, multi-block, restarts, dropped codes)", ops_sent);
    $display("%0d digests requested, %0d digest words checked", digests_sent, words_seen);
    if (!timed_out && errors == 0 && digest_words_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("watchdog expired with %0d words pending", digest_words_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/md5_pkg.sv
rtl/core/md5_ram.sv
rtl/core/md5_front.sv
rtl/core/md5_back.sv
rtl/core/md5_hash_engine.sv
verif/tb_md5_hash_engine.sv
